// ----- src/dfsbn_pkg.sv -----
package dfsbn_pkg;

   localparam int OPCODE_W    = 2;
   localparam int BLOCK_ID_W  = 6;
   localparam int ORDER_W     = 6;
   localparam int COUNT_REG_W = 7;

   typedef logic [OPCODE_W-1:0]    opcode_type;
   typedef logic [BLOCK_ID_W-1:0]  block_id_type;
   typedef logic [ORDER_W-1:0]     order_type;
   typedef logic [COUNT_REG_W-1:0] count_reg_type;

   localparam opcode_type OP_ADD_EDGE = 2'd0;
   localparam opcode_type OP_RUN      = 2'd1;
   localparam opcode_type OP_CLEAR    = 2'd2;

   typedef struct packed {
      opcode_type   opcode;
      block_id_type from_block;
      block_id_type to_block;
   } req_payload_type;

   typedef struct packed {
      block_id_type block_id;
      order_type    order_number;
      logic         last;
   } rsp_payload_type;

   // controller -> datapath
   typedef struct packed {
      logic latch_req;
      logic edge_read;
      logic edge_write;
      logic clear_counts;
      logic run_init;
      logic top_read;
      logic cur_load;
      logic cnt_load;
      logic succ_read;
      logic succ_visit;
      logic pop;
      logic emit_read;
      logic emit_out;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_more;
      logic pushed;
      logic depth_one;
      logic emit_last;
      logic out_free;
   } ctrl_status_type;

endpackage

// ----- src/dfsbn_ctrl.sv -----
module dfsbn_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  dfsbn_pkg::opcode_type      req_opcode,
   output logic                       req_stall,
   input  dfsbn_pkg::ctrl_status_type status,
   output dfsbn_pkg::ctrl_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_EDGE_RD  = 4'd1;
   localparam logic [3:0] ST_EDGE_WR  = 4'd2;
   localparam logic [3:0] ST_RUN_INIT = 4'd3;
   localparam logic [3:0] ST_TOP      = 4'd4;
   localparam logic [3:0] ST_CUR      = 4'd5;
   localparam logic [3:0] ST_CNT      = 4'd6;
   localparam logic [3:0] ST_SCAN     = 4'd7;
   localparam logic [3:0] ST_SUCC     = 4'd8;
   localparam logic [3:0] ST_POP      = 4'd9;
   localparam logic [3:0] ST_EMIT_RD  = 4'd10;
   localparam logic [3:0] ST_EMIT_OUT = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               case (req_opcode)
                  dfsbn_pkg::OP_ADD_EDGE: state_in = ST_EDGE_RD;
                  dfsbn_pkg::OP_RUN:      state_in = ST_RUN_INIT;
                  dfsbn_pkg::OP_CLEAR:    cmd.clear_counts = 1'b1;
                  default:                state_in = ST_IDLE;
               endcase
            end
         end
         ST_EDGE_RD: begin
            cmd.edge_read = 1'b1;
            state_in      = ST_EDGE_WR;
         end
         ST_EDGE_WR: begin
            cmd.edge_write = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_RUN_INIT: begin
            cmd.run_init = 1'b1;
            state_in     = ST_TOP;
         end
         ST_TOP: begin
            cmd.top_read = 1'b1;
            state_in     = ST_CUR;
         end
         ST_CUR: begin
            cmd.cur_load = 1'b1;
            state_in     = ST_CNT;
         end
         ST_CNT: begin
            cmd.cnt_load = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_more) begin
               cmd.succ_read = 1'b1;
               state_in      = ST_SUCC;
            end else if (status.pushed) begin
               state_in = ST_TOP;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_SUCC: begin
            cmd.succ_visit = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = status.depth_one ? ST_EMIT_RD : ST_TOP;
         end
         ST_EMIT_RD: begin
            if (status.out_free) begin
               cmd.emit_read = 1'b1;
               state_in      = ST_EMIT_OUT;
            end
         end
         ST_EMIT_OUT: begin
            cmd.emit_out = 1'b1;
            state_in     = status.emit_last ? ST_IDLE : ST_EMIT_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/dfsbn_datapath.sv -----
module dfsbn_datapath #(
   parameter int MAX_BLOCKS     = 64,
   parameter int MAX_SUCCESSORS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dfsbn_pkg::ctrl_cmd_type     cmd,
   output dfsbn_pkg::ctrl_status_type  status,
   input  logic                        csr_write_enable,
   input  dfsbn_pkg::count_reg_type    csr_write_data,
   input  dfsbn_pkg::req_payload_type  req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output dfsbn_pkg::rsp_payload_type  rsp_payload
);

   localparam int BW = $clog2(MAX_BLOCKS);
   localparam int NW = $clog2(MAX_BLOCKS + 1);
   localparam int CW = $clog2(MAX_SUCCESSORS + 1);
   localparam int TD = MAX_BLOCKS * MAX_SUCCESSORS;
   localparam int TW = (TD > 1) ? $clog2(TD) : 1;

   // block count register and clamped count in use
   dfsbn_pkg::count_reg_type block_count_ff, block_count_in;
   logic [NW-1:0]            blocks_used;

   // latched edge item
   dfsbn_pkg::block_id_type  from_ff, from_in;
   dfsbn_pkg::block_id_type  to_ff, to_in;

   // successor lists
   dfsbn_pkg::block_id_type  succ_mem [TD];
   dfsbn_pkg::block_id_type  succ_rd_ff;
   logic [TW-1:0]            succ_wr_addr;
   logic [TW-1:0]            succ_rd_addr;
   logic [CW-1:0]            count_mem [MAX_BLOCKS];
   logic [CW-1:0]            count_rd_ff;
   logic [MAX_BLOCKS-1:0]    count_valid_ff, count_valid_in;
   logic                     cvalid_rd_ff;
   logic [BW-1:0]            count_rd_addr;
   logic [CW-1:0]            cnt_eff;
   logic                     edge_ok;

   // walk state
   logic [BW-1:0]            stack_mem [MAX_BLOCKS];
   logic [BW-1:0]            stack_rd_ff;
   logic [NW-1:0]            depth_ff, depth_in;
   logic [NW-1:0]            depth_less;
   logic [NW-1:0]            reached_ff, reached_in;
   logic [NW-1:0]            next_ff, next_in;
   logic [MAX_BLOCKS-1:0]    visited_ff, visited_in;
   logic [BW-1:0]            cur_ff, cur_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [CW-1:0]            k_ff, k_in;
   logic                     pushed_ff, pushed_in;
   logic                     fresh;

   // emission
   dfsbn_pkg::order_type     number_mem [MAX_BLOCKS];
   dfsbn_pkg::order_type     number_rd_ff;
   logic [BW-1:0]            b_ff, b_in;
   logic [NW-1:0]            low_ff, low_in;
   logic [NW-1:0]            unreached;
   logic                     emit_last;
   logic                     rsp_valid_ff, rsp_valid_in;
   dfsbn_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   always_comb begin
      if (block_count_ff == '0) begin
         blocks_used = NW'(1);
      end else if (32'(block_count_ff) > MAX_BLOCKS) begin
         blocks_used = NW'(MAX_BLOCKS);
      end else begin
         blocks_used = NW'(block_count_ff);
      end
   end

   assign cnt_eff       = cvalid_rd_ff ? count_rd_ff : '0;
   assign edge_ok       = (32'(from_ff) < 32'(blocks_used)) &&
                          (32'(to_ff) < 32'(blocks_used)) &&
                          (32'(cnt_eff) < MAX_SUCCESSORS);
   assign succ_wr_addr  = TW'(32'(from_ff[BW-1:0]) * MAX_SUCCESSORS + 32'(cnt_eff));
   assign succ_rd_addr  = TW'(32'(cur_ff) * MAX_SUCCESSORS + 32'(k_ff));
   assign count_rd_addr = cmd.edge_read ? from_ff[BW-1:0] : stack_rd_ff;
   assign depth_less    = depth_ff - NW'(1);
   assign fresh         = (32'(succ_rd_ff) < 32'(blocks_used)) &&
                          !visited_ff[succ_rd_ff[BW-1:0]];
   assign unreached     = blocks_used - reached_ff;
   assign emit_last     = ((32'(b_ff) + 32'd1) == 32'(blocks_used));

   assign status.scan_more = (k_ff < cnt_ff);
   assign status.pushed    = pushed_ff;
   assign status.depth_one = (depth_ff == NW'(1));
   assign status.emit_last = emit_last;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      block_count_in = block_count_ff;
      from_in        = from_ff;
      to_in          = to_ff;
      count_valid_in = count_valid_ff;
      depth_in       = depth_ff;
      reached_in     = reached_ff;
      next_in        = next_ff;
      visited_in     = visited_ff;
      cur_in         = cur_ff;
      cnt_in         = cnt_ff;
      k_in           = k_ff;
      pushed_in      = pushed_ff;
      b_in           = b_ff;
      low_in         = low_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;

      if (csr_write_enable) begin
         block_count_in = csr_write_data;
      end
      if (cmd.latch_req) begin
         from_in = req_payload.from_block;
         to_in   = req_payload.to_block;
      end
      if (cmd.clear_counts) begin
         count_valid_in = '0;
      end
      if (cmd.edge_write && edge_ok) begin
         count_valid_in[from_ff[BW-1:0]] = 1'b1;
      end
      if (cmd.run_init) begin
         visited_in    = '0;
         visited_in[0] = 1'b1;
         depth_in      = NW'(1);
         reached_in    = NW'(1);
         next_in       = '0;
         b_in          = '0;
         low_in        = '0;
      end
      if (cmd.cur_load) begin
         cur_in = stack_rd_ff;
      end
      if (cmd.cnt_load) begin
         cnt_in    = cnt_eff;
         k_in      = '0;
         pushed_in = 1'b0;
      end
      if (cmd.succ_visit) begin
         k_in = k_ff + CW'(1);
         if (fresh) begin
            visited_in[succ_rd_ff[BW-1:0]] = 1'b1;
            reached_in = reached_ff + NW'(1);
            depth_in   = depth_ff + NW'(1);
            pushed_in  = 1'b1;
         end
      end
      if (cmd.pop) begin
         depth_in = depth_less;
         next_in  = next_ff + NW'(1);
      end
      if (cmd.emit_out) begin
         rsp_valid_in            = 1'b1;
         rsp_payload_in.block_id = dfsbn_pkg::block_id_type'(b_ff);
         rsp_payload_in.last     = emit_last;
         if (visited_ff[b_ff]) begin
            rsp_payload_in.order_number =
               number_rd_ff + dfsbn_pkg::order_type'(unreached);
         end else begin
            rsp_payload_in.order_number = dfsbn_pkg::order_type'(low_ff);
            low_in = low_ff + NW'(1);
         end
         b_in = b_ff + BW'(1);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= dfsbn_pkg::count_reg_type'(1);
         count_valid_ff <= '0;
         depth_ff       <= '0;
         reached_ff     <= '0;
         next_ff        <= '0;
         visited_ff     <= '0;
         pushed_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         block_count_ff <= block_count_in;
         count_valid_ff <= count_valid_in;
         depth_ff       <= depth_in;
         reached_ff     <= reached_in;
         next_ff        <= next_in;
         visited_ff     <= visited_in;
         pushed_ff      <= pushed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      from_ff        <= from_in;
      to_ff          <= to_in;
      cur_ff         <= cur_in;
      cnt_ff         <= cnt_in;
      k_ff           <= k_in;
      b_ff           <= b_in;
      low_ff         <= low_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // successor list memory
   always_ff @(posedge clock) begin
      if (cmd.edge_write && edge_ok) begin
         succ_mem[succ_wr_addr] <= to_ff;
      end
      if (cmd.succ_read) begin
         succ_rd_ff <= succ_mem[succ_rd_addr];
      end
   end

   // per-block edge count; entries gated by count_valid_ff
   always_ff @(posedge clock) begin
      if (cmd.edge_write && edge_ok) begin
         count_mem[from_ff[BW-1:0]] <= cnt_eff + CW'(1);
      end
      if (cmd.edge_read || cmd.cur_load) begin
         count_rd_ff  <= count_mem[count_rd_addr];
         cvalid_rd_ff <= count_valid_ff[count_rd_addr];
      end
   end

   // walk stack
   always_ff @(posedge clock) begin
      if (cmd.run_init) begin
         stack_mem[0] <= '0;
      end else if (cmd.succ_visit && fresh) begin
         stack_mem[depth_ff[BW-1:0]] <= succ_rd_ff[BW-1:0];
      end
      if (cmd.top_read) begin
         stack_rd_ff <= stack_mem[depth_less[BW-1:0]];
      end
   end

   // finish order per block
   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         number_mem[cur_ff] <= dfsbn_pkg::order_type'(next_ff);
      end
      if (cmd.emit_read) begin
         number_rd_ff <= number_mem[b_ff];
      end
   end

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_out |-> !rsp_valid_ff)
      else $error("result loaded over a pending transaction");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (depth_ff != '0))
      else $error("pop from empty walk stack");

   a_reached_bound: assert property (@(posedge clock) disable iff (reset)
      reached_ff <= NW'(MAX_BLOCKS))
      else $error("reached count beyond block capacity");

   a_numbers_behind_reached: assert property (@(posedge clock) disable iff (reset)
      next_ff <= reached_ff)
      else $error("more blocks numbered than reached");

endmodule

// ----- src/dfs_postorder_block_numbering.sv -----
// Control-flow graph block numbering (post-order walk from block 0).
// Request channel (req_valid / req_stall / req_payload): one transaction is
// an add-edge, a run, or a clear-edges command. Result channel (rsp_valid /
// rsp_stall / rsp_payload): a run returns one transaction per block in use,
// block 0 upward, with last set on the final one. Edge and clear commands
// return nothing. csr_write_enable / csr_write_data write the block count;
// write it only while no command is in flight.
// A clear resets the edge counts as it is accepted; an edge load reads the
// count, then writes the list. A run does a setup step, then each time a
// block is on top of the stack reads the top, loads the block and its count
// and scans each stored successor (every reached block is on top at most
// twice); it pops finished blocks and emits each result as a number read,
// then an output write; the single-port successor memory and stack set pace.
// req_stall is high from acceptance until the last result of a run is in the
// output register, so one command is worked on at a time.
// Reset clears the edge counts (lists read as empty), the output register
// and the controller; the block count returns to 1. No clearing pass.
// A stalled result holds in the output register; the walk waits for it.
module dfs_postorder_block_numbering #(
   parameter int MAX_BLOCKS     = 64,
   parameter int MAX_SUCCESSORS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   // command channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  dfsbn_pkg::req_payload_type req_payload,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output dfsbn_pkg::rsp_payload_type rsp_payload,
   // block count register
   input  logic                       csr_write_enable,
   input  dfsbn_pkg::count_reg_type   csr_write_data
);

   dfsbn_pkg::ctrl_cmd_type    cmd;
   dfsbn_pkg::ctrl_status_type status;

   // sequencer: decodes a command transaction and steps the walk
   dfsbn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_payload.opcode),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   // memories (successor lists, counts, stack, numbers), walk counters,
   // block count register and the result register
   dfsbn_datapath #(
      .MAX_BLOCKS     (MAX_BLOCKS),
      .MAX_SUCCESSORS (MAX_SUCCESSORS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

endmodule
